// File: sv/mtf_pkg.sv
package mtf_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_MOVE   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    // Per-cell control from the list controller
    typedef struct packed {
        logic shift;     // take the neighbor's value (the head cell takes the input value) this cycle
        logic occupied;  // cell holds a live entry
    } cell_ctrl_t;

endpackage

// File: sv/mtf_cell.sv
module mtf_cell (
    input  logic                              clk,
    input  mtf_pkg::cell_ctrl_t               ctrl,
    input  logic signed [mtf_pkg::DATA_W-1:0] key,
    input  logic signed [mtf_pkg::DATA_W-1:0] prev_data,
    input  logic                              found_in,
    output logic signed [mtf_pkg::DATA_W-1:0] data,
    output logic                              found_out
);

    logic signed [mtf_pkg::DATA_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= prev_data;
        end
    end

    assign data      = data_reg;
    // found_out is high once any cell at or before this one matches
    assign found_out = found_in | (ctrl.occupied & (data_reg == key));

endmodule

// File: sv/move_to_front_list.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    action[1:0], value[31:0]
// out      out  out_valid/out_ready  entry_value[31:0], status[1:0], last
//
// On insert and move every cell compares against value in parallel and the
// chain shifts by one place in the same edge.
// Read out enters S_READ, then loads the entries from head to tail into the output
// register as it frees; in_ready is low until the tail entry is loaded into it.
// The output register decouples the sides; a stalled out_ready holds in_ready low.
// Reset empties the list; cell contents are not cleared.
module move_to_front_list (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        action,
    input  logic signed [mtf_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mtf_pkg::DATA_W-1:0] entry_value,
    output logic [1:0]                        status,
    output logic                              last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    logic [mtf_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [mtf_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic                               out_valid_reg, out_valid_next;
    logic signed [mtf_pkg::DATA_W-1:0]  entry_value_reg, entry_value_next;
    logic [1:0]                         status_reg, status_next;
    logic                               last_reg, last_next;

    mtf_pkg::cell_ctrl_t                ctrl [mtf_pkg::CAPACITY];
    logic signed [mtf_pkg::DATA_W-1:0]  cell_data [mtf_pkg::CAPACITY];
    logic                               found [mtf_pkg::CAPACITY+1];

    logic slot_free;
    logic accept;
    logic is_full;
    logic is_empty;
    logic hit;
    logic do_insert;
    logic do_move;
    logic read_last;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign is_full   = (count_reg == mtf_pkg::COUNT_W'(mtf_pkg::CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign hit       = found[mtf_pkg::CAPACITY];
    assign do_insert = accept && (action == mtf_pkg::ACT_INSERT) && !is_full;
    assign do_move   = accept && (action == mtf_pkg::ACT_MOVE) && !is_empty && hit;
    assign read_last = ({1'b0, idx_reg} == count_reg - 1'b1);

    assign found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < mtf_pkg::CAPACITY; g++)
        begin : g_cell
            always_comb
            begin
                ctrl[g].occupied = (mtf_pkg::COUNT_W'(g) < count_reg);
                // Insert shifts every cell; move shifts every cell up to and including the first match
                ctrl[g].shift    = do_insert || (do_move && !found[g]);
            end

            if (g == 0)
            begin : g_head
                mtf_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl[g]),
                    .key       (value),
                    .prev_data (value),
                    .found_in  (found[g]),
                    .data      (cell_data[g]),
                    .found_out (found[g+1])
                );
            end
            else
            begin : g_body
                mtf_cell u_cell (
                    .clk       (clk),
                    .ctrl      (ctrl[g]),
                    .key       (value),
                    .prev_data (cell_data[g-1]),
                    .found_in  (found[g]),
                    .data      (cell_data[g]),
                    .found_out (found[g+1])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        entry_value_next = entry_value_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        mtf_pkg::ACT_INSERT:
                        begin
                            out_valid_next   = 1'b1;
                            entry_value_next = value;
                            last_next        = 1'b1;
                            if (is_full)
                            begin
                                status_next = mtf_pkg::STAT_FULL;
                            end
                            else
                            begin
                                status_next = mtf_pkg::STAT_OK;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        mtf_pkg::ACT_MOVE:
                        begin
                            out_valid_next   = 1'b1;
                            entry_value_next = value;
                            last_next        = 1'b1;
                            priority if (is_empty)
                            begin
                                status_next = mtf_pkg::STAT_EMPTY;
                            end
                            else if (!hit)
                            begin
                                status_next = mtf_pkg::STAT_NOT_FOUND;
                            end
                            else
                            begin
                                status_next = mtf_pkg::STAT_OK;
                            end
                        end
                        mtf_pkg::ACT_READ:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next   = 1'b1;
                                entry_value_next = '0;
                                status_next      = mtf_pkg::STAT_EMPTY;
                                last_next        = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            // unused action code: transaction dropped silently
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    entry_value_next = cell_data[idx_reg];
                    status_next      = mtf_pkg::STAT_OK;
                    last_next        = read_last;
                    if (read_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_value_reg <= entry_value_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign entry_value = entry_value_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

// File: sv/mtf_checker.sv
module mtf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic [1:0]                        action,
    input logic signed [mtf_pkg::DATA_W-1:0] value,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [mtf_pkg::DATA_W-1:0] entry_value,
    input logic [1:0]                        status,
    input logic                              last
);

    // Held result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(entry_value))
        else $error("output transaction changed while stalled");

    // Insert and move answer in the next cycle with the value acted upon
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == mtf_pkg::ACT_INSERT || action == mtf_pkg::ACT_MOVE)
        |=> out_valid && last && (entry_value == $past(value)))
        else $error("insert/move result missing or wrong");

    // A read out in progress blocks new transactions
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input accepted during read out");

    // Error statuses always end the item
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mtf_pkg::STAT_FULL || status == mtf_pkg::STAT_NOT_FOUND
                      || status == mtf_pkg::STAT_EMPTY) |-> last)
        else $error("error status without last");

endmodule

bind move_to_front_list mtf_checker u_mtf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .entry_value (entry_value),
    .status      (status),
    .last        (last)
);
